/* hdl/e2q_pkg.sv */
// Package: widths, constants and arctangent table for the Euler-to-quaternion core.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int QUAT_BITS  = 16;
  localparam int TRIG_STEPS = 14;
  localparam int CW         = 34;  // CORDIC datapath, signed Q3.30
  localparam int PW         = 32;  // product operands, signed Q1.30

  typedef logic signed [CW-1:0] cval_t;

  localparam cval_t PI_Q30      = 34'sd3373259426;
  localparam cval_t HALF_PI_Q30 = 34'sd1686629713;
  localparam cval_t GAIN_Q30 = cval_t'(64'sd652032874 +
    ((64'sd434688583 + (64'sd1 <<< (2 * TRIG_STEPS - 1))) >>> (2 * TRIG_STEPS)));

  function automatic cval_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sd843314857;   1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043837;   3: atan_q30 = 34'sd133525159;
      4: atan_q30 = 34'sd67021687;    5: atan_q30 = 34'sd33543516;
      6: atan_q30 = 34'sd16775851;    7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194283;     9: atan_q30 = 34'sd2097149;
      default: atan_q30 = (i < 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* hdl/e2q_cordic.sv */
// Pipelined rotation-mode CORDIC: half-angle sine and cosine, one step per stage.
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic
  import e2q_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [PW-1:0]              sin_q,
  output logic signed [PW-1:0]              cos_q
);
  cval_t x_r [TRIG_STEPS+1];
  cval_t y_r [TRIG_STEPS+1];
  cval_t z_r [TRIG_STEPS+1];
  logic  flip_r [TRIG_STEPS+1];

  cval_t z0, zf;
  logic  fl;
  always_comb begin
    z0 = cval_t'(angle) <<< (30 - (ANGLE_BITS - 2));
    zf = z0;
    fl = 1'b0;
    if (z0 > HALF_PI_Q30) begin
      zf = z0 - PI_Q30;
      fl = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      zf = z0 + PI_Q30;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= zf;
      flip_r[0] <= fl;
    end
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  assign sin_q = PW'(flip_r[TRIG_STEPS] ? -y_r[TRIG_STEPS] : y_r[TRIG_STEPS]);
  assign cos_q = PW'(flip_r[TRIG_STEPS] ? -x_r[TRIG_STEPS] : x_r[TRIG_STEPS]);
endmodule
`default_nettype wire

/* hdl/e2q_combine.sv */
// Quaternion stages: pair products, round, triple products, sum, round and clamp.
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine
  import e2q_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [PW-1:0]    sr,
  input  wire logic signed [PW-1:0]    cr,
  input  wire logic signed [PW-1:0]    sp,
  input  wire logic signed [PW-1:0]    cp,
  input  wire logic signed [PW-1:0]    sy,
  input  wire logic signed [PW-1:0]    cy,
  output logic signed [QUAT_BITS-1:0]  qw,
  output logic signed [QUAT_BITS-1:0]  qx,
  output logic signed [QUAT_BITS-1:0]  qy,
  output logic signed [QUAT_BITS-1:0]  qz
);
  localparam int MW = 2 * PW;
  localparam int SH = 62 - QUAT_BITS;
  localparam logic signed [MW:0] ONE = (MW+1)'(64'sd1 <<< (QUAT_BITS - 2));

  logic signed [MW-1:0] pcc_r, pss_r, psc_r, pcs_r;
  logic signed [PW-1:0] sy_r, cy_r;
  logic signed [PW-1:0] rcc_r, rss_r, rsc_r, rcs_r, sy2_r, cy2_r;
  logic signed [MW-1:0] t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;
  logic signed [MW:0]   sw_r, sx_r, sy3_r, sz_r;

  function automatic logic signed [PW-1:0] rnd30(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] t;
    t = (v + (MW'(1) <<< 29)) >>> 30;
    return t[PW-1:0];
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] qout(input logic signed [MW:0] v);
    logic signed [MW:0] t;
    t = (v + ((MW+1)'(1) <<< (SH - 1))) >>> SH;
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    return t[QUAT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r <= cr * cp;  pss_r <= sr * sp;
      psc_r <= sr * cp;  pcs_r <= cr * sp;
      sy_r  <= sy;       cy_r  <= cy;
      rcc_r <= rnd30(pcc_r);  rss_r <= rnd30(pss_r);
      rsc_r <= rnd30(psc_r);  rcs_r <= rnd30(pcs_r);
      sy2_r <= sy_r;          cy2_r <= cy_r;
      t0_r <= rcc_r * cy2_r;  t1_r <= rss_r * sy2_r;
      t2_r <= rsc_r * cy2_r;  t3_r <= rcs_r * sy2_r;
      t4_r <= rcs_r * cy2_r;  t5_r <= rsc_r * sy2_r;
      t6_r <= rcc_r * sy2_r;  t7_r <= rss_r * cy2_r;
      sw_r  <= (MW+1)'(t0_r) + (MW+1)'(t1_r);
      sx_r  <= (MW+1)'(t2_r) - (MW+1)'(t3_r);
      sy3_r <= (MW+1)'(t4_r) + (MW+1)'(t5_r);
      sz_r  <= (MW+1)'(t6_r) - (MW+1)'(t7_r);
      qw <= qout(sw_r);  qx <= qout(sx_r);
      qy <= qout(sy3_r); qz <= qout(sz_r);
    end
  end
endmodule
`default_nettype wire

/* hdl/euler_to_quaternion_core.sv */
// Top level: Z-Y-X Euler angles to unit quaternion, fully pipelined.
// One angle triple is accepted per cycle while not stalled; stages: one fold
// stage, one CORDIC stage per iteration, five product/round stages.
// A stall freezes the whole pipeline; in_stall follows out_stall only while
// the output holds a valid result.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_core
  import e2q_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  wire logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  wire logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [QUAT_BITS-1:0]       out_quat_w,
  output logic signed [QUAT_BITS-1:0]       out_quat_x,
  output logic signed [QUAT_BITS-1:0]       out_quat_y,
  output logic signed [QUAT_BITS-1:0]       out_quat_z
);
  localparam int DEPTH = TRIG_STEPS + 6;

  logic [DEPTH-1:0] vld_r;
  logic en;
  logic signed [PW-1:0] sr, cr, sp, cp, sy, cy;

  assign en        = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  e2q_cordic u_roll  (.clk, .en, .angle(in_roll_angle),  .sin_q(sr), .cos_q(cr));
  e2q_cordic u_pitch (.clk, .en, .angle(in_pitch_angle), .sin_q(sp), .cos_q(cp));
  e2q_cordic u_yaw   (.clk, .en, .angle(in_yaw_angle),   .sin_q(sy), .cos_q(cy));

  e2q_combine u_comb (
    .clk, .en, .sr, .cr, .sp, .cp, .sy, .cy,
    .qw(out_quat_w), .qx(out_quat_x), .qy(out_quat_y), .qz(out_quat_z)
  );
endmodule
`default_nettype wire
